// File: design/first_fit_run_allocator_assert.svh
// ----------------------------------------------------------------------------
// first fit run allocator assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_RUN_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RUN_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FFRA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffra check failed");
`define FFRA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffra check failed");
`else
`define FFRA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FFRA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// shared types and constants of the first fit run allocator
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int START_W = 7;
  localparam int COUNT_W = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               granted;
    logic [START_W-1:0] run_start;
  } result_t;

endpackage

// File: design/ffra_map.sv
// ----------------------------------------------------------------------------
// ffra_map
// reservation map, one bit per cell, one write and one registered read port
// ----------------------------------------------------------------------------
module ffra_map #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic          wd,
  input  logic [AW-1:0] ra,
  output logic          rd
);

  logic mem [DEPTH];
  logic rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

// File: design/first_fit_run_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_run_allocator
// first fit allocator of contiguous cell runs over a one bit reservation map
// ----------------------------------------------------------------------------
// After reset the map is cleared one cell per cycle with in_ready low. An
// allocate word scans the map from cell 0, one cell per cycle through the
// single read port, then marks the found run one cell per cycle; the result
// is handed over once the output register is free. A free word clears
// cell_count cells from in_start_cell, clamped at the pool end; zero counts
// and out of range words go straight to the result.
// One word is in work at a time; a finished result waits in the output
// register while the next word is taken.
module first_fit_run_allocator #(
  parameter int POOL_CELLS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [ffra_pkg::START_W-1:0] in_start_cell,
  input  logic [ffra_pkg::COUNT_W-1:0] in_cell_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [ffra_pkg::START_W-1:0] out_run_start
);

  import ffra_pkg::*;

  `include "first_fit_run_allocator_assert.svh"

  localparam int AW = $clog2(POOL_CELLS);
  localparam int SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
  localparam logic [AW:0]   POOL_N = (AW + 1)'(POOL_CELLS);
  localparam logic [AW:0]   LAST_N = (AW + 1)'(POOL_CELLS - 1);
  localparam logic [AW-1:0] LAST_A = AW'(POOL_CELLS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [AW:0]        addr_r, addr_nxt;
  logic [AW-1:0]      chk_addr_r, chk_addr_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [COUNT_W-1:0] run_r, run_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]      mark_addr_r, mark_addr_nxt;
  logic               mark_bit_r, mark_bit_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;

  logic               map_we;
  logic [AW-1:0]      map_wa;
  logic               map_wd;
  logic               map_rd;
  logic [COUNT_W-1:0] run_inc;
  logic [SW-1:0]      first_w;

  ffra_map #(
    .DEPTH (POOL_CELLS),
    .AW    (AW)
  ) u_map (
    .clk (clk),
    .we  (map_we),
    .wa  (map_wa),
    .wd  (map_wd),
    .ra  (addr_r[AW-1:0]),
    .rd  (map_rd)
  );

  assign run_inc = run_r + COUNT_W'(1);
  assign first_w = SW'(chk_addr_r) + SW'(1) - SW'(count_r);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_vld_nxt   = chk_vld_r;
    run_nxt       = run_r;
    count_nxt     = count_r;
    mark_addr_nxt = mark_addr_r;
    mark_bit_nxt  = mark_bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_res_nxt   = out_res_r;
    map_we        = 1'b0;
    map_wa        = mark_addr_r;
    map_wd        = mark_bit_r;
    unique case (state_r)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_wa = addr_r[AW-1:0];
        map_wd = 1'b0;
        if (addr_r == LAST_N) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + (AW + 1)'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          count_nxt     = in_cell_count;
          addr_nxt      = '0;
          chk_vld_nxt   = 1'b0;
          run_nxt       = '0;
          mark_addr_nxt = AW'(in_start_cell);
          mark_bit_nxt  = 1'b0;
          res_nxt       = '{granted: 1'b1, run_start: '0};
          if (in_opcode == OP_ALLOC) begin
            if (in_cell_count == '0) begin
              state_nxt = ST_FIN;
            end else if (32'(in_cell_count) > 32'(POOL_CELLS)) begin
              res_nxt   = '{granted: 1'b0, run_start: '0};
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_SCAN;
            end
          end else begin
            if (in_cell_count != '0 && 32'(in_start_cell) < 32'(POOL_CELLS)) begin
              state_nxt = ST_MARK;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_SCAN: begin
        chk_vld_nxt  = (addr_r < POOL_N);
        chk_addr_nxt = addr_r[AW-1:0];
        if (addr_r < POOL_N) begin
          addr_nxt = addr_r + (AW + 1)'(1);
        end
        if (chk_vld_r) begin
          if (map_rd) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_inc;
          end
          if (!map_rd && run_inc == count_r) begin
            res_nxt       = '{granted: 1'b1, run_start: START_W'(first_w)};
            mark_addr_nxt = AW'(first_w);
            mark_bit_nxt  = 1'b1;
            chk_vld_nxt   = 1'b0;
            state_nxt     = ST_MARK;
          end else if (chk_addr_r == LAST_A) begin
            res_nxt     = '{granted: 1'b0, run_start: '0};
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_FIN;
          end
        end
      end
      ST_MARK: begin
        map_we        = 1'b1;
        count_nxt     = count_r - COUNT_W'(1);
        mark_addr_nxt = mark_addr_r + AW'(1);
        if (count_r == COUNT_W'(1) || mark_addr_r == LAST_A) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r  <= chk_addr_nxt;
    run_r       <= run_nxt;
    count_r     <= count_nxt;
    mark_addr_r <= mark_addr_nxt;
    mark_bit_r  <= mark_bit_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_granted   = out_res_r.granted;
  assign out_run_start = out_res_r.run_start;

  `FFRA_ASSERT_NXT(a_fin_loads, clk, rst_n, state_r == ST_FIN && (!out_valid_r || out_ready), out_valid_r && state_r == ST_IDLE)
  `FFRA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_r && !out_res_r.granted, out_res_r.run_start == '0)
  `FFRA_ASSERT_IMP(a_run_bound, clk, rst_n, state_r == ST_SCAN && chk_vld_r, run_r < count_r)
  `FFRA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE && state_r != ST_CLEAR)

endmodule
